// File: rtl/kst_pkg.sv
// Package for the keyed slot table: beat types, command codes and the
// control structs that pass between the top level and its slot cells.
// No dependencies.
package kst_pkg;

	localparam int SLOT_W = 5;
	localparam int PLAYER_W = 4;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_LOOKUP_KEY = 3'd1;
	localparam logic [2:0] CMD_LOOKUP_POS = 3'd2;
	localparam logic [2:0] CMD_REMOVE_KEY = 3'd3;
	localparam logic [2:0] CMD_REMOVE_ALL = 3'd4;

	localparam logic [7:0] WILD_ID = 8'hFF;
	localparam logic [15:0] POS_BIAS = 16'd7;

	// Command beat
	typedef struct packed {
		logic [2:0] command;
		logic [7:0] local_id;
		logic [7:0] map_num;
		logic [7:0] map_group;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} cmd_t;

	// Result beat
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic failed;
	} res_t;

	// Broadcast from the top level to every cell
	typedef struct packed {
		logic fire;
		logic ins_ok;
		logic [PLAYER_W-1:0] player;
		cmd_t req;
	} kst_op_t;

	// Priority chain handed from one cell to the next
	typedef struct packed {
		logic key_seen;
		logic exact_seen;
		logic pos_seen;
		logic free_seen;
	} kst_chain_t;

	// Per-cell first-hit flags
	typedef struct packed {
		logic key_first;
		logic pos_first;
		logic free_first;
	} kst_hit_t;

endpackage

// File: rtl/kst_cell.sv
// One slot of the keyed slot table: holds the entry, compares it against
// the broadcast command and takes part in the priority chain. Uses kst_pkg.
module kst_cell #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  kst_pkg::kst_op_t op,
	input  kst_pkg::kst_chain_t chain_in,
	output kst_pkg::kst_chain_t chain_out,
	output kst_pkg::kst_hit_t hit
);
	import kst_pkg::*;

	logic active_q;
	logic [7:0] ident_q;
	logic [7:0] map_num_q;
	logic [7:0] map_grp_q;
	logic [15:0] pos_x_q;
	logic [15:0] pos_y_q;

	logic id_eq, map_eq, exact_m, key_m, pos_m, free_m;
	logic is_player;

	// Compare the stored entry with the command
	assign id_eq = ident_q == op.req.local_id;
	assign map_eq = (map_num_q == op.req.map_num) && (map_grp_q == op.req.map_group);
	assign exact_m = active_q && id_eq && map_eq;
	assign key_m = (op.req.local_id == WILD_ID) ? (active_q && id_eq) : exact_m;
	assign pos_m = active_q && (pos_x_q == $unsigned(op.req.x))
		&& (pos_y_q == $unsigned(op.req.y));
	assign free_m = !active_q;
	assign is_player = int'(op.player) == IDX;

	// Pass the priority chain on to the next cell
	always_comb begin
		chain_out.key_seen = chain_in.key_seen | key_m;
		chain_out.exact_seen = chain_in.exact_seen | exact_m;
		chain_out.pos_seen = chain_in.pos_seen | pos_m;
		chain_out.free_seen = chain_in.free_seen | free_m;
		hit.key_first = key_m & !chain_in.key_seen;
		hit.pos_first = pos_m & !chain_in.pos_seen;
		hit.free_first = free_m & !chain_in.free_seen;
	end

	// Update the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (op.fire) begin
			case (op.req.command)
				CMD_INSERT: begin
					if (op.ins_ok && hit.free_first) active_q <= 1'b1;
				end
				CMD_REMOVE_KEY: begin
					if (hit.key_first) active_q <= 1'b0;
				end
				CMD_REMOVE_ALL: begin
					if (!is_player) active_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Load the entry on a successful insert into this slot
	always_ff @(posedge clk) begin
		if (op.fire && (op.req.command == CMD_INSERT) && op.ins_ok && hit.free_first) begin
			ident_q <= op.req.local_id;
			map_num_q <= op.req.map_num;
			map_grp_q <= op.req.map_group;
			pos_x_q <= $unsigned(op.req.x) + POS_BIAS;
			pos_y_q <= $unsigned(op.req.y) + POS_BIAS;
		end
	end

endmodule

// File: rtl/keyed_slot_table_top.sv
// Top level of the keyed slot table: command register, row of slot cells,
// result encoding and output register. Uses kst_pkg and kst_cell.
//
// Usage:
//   A command beat on cmd is taken when cmd_valid and cmd_ready are high.
//   It is registered in the command register; every cell then compares in
//   parallel, a priority chain through the row picks the lowest slot and,
//   once the output register is free, the table is updated and the result
//   beat is loaded into it. A new command is taken only after the last one
//   has left the command register.
//   Each command gives exactly one result beat (slot, failed); slot SLOTS
//   means none. player_slot is written through cfg_valid/cfg_data, which is
//   always ready; write it only while no command is in flight.
//   If the receiver stalls, the result holds in the output register; one
//   more command may be taken and waits registered until the result leaves.
//   Reset empties every slot, clears player_slot and drops any beat in flight.
module keyed_slot_table_top #(
	parameter int SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  kst_pkg::cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output kst_pkg::res_t res,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [kst_pkg::PLAYER_W-1:0] cfg_data
);
	import kst_pkg::*;

	localparam int IW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] NONE_IDX = IW'(SLOTS);
	localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(SLOTS);

	logic cmd_valid_s1;
	cmd_t cmd_s1;
	logic [PLAYER_W-1:0] player_q;
	logic advance;
	logic ins_ok;
	kst_op_t op;
	kst_chain_t chain [SLOTS+1];
	kst_hit_t hits [SLOTS];
	logic [SLOTS-1:0] key_vec, pos_vec, free_vec;
	logic [IW-1:0] key_idx, pos_idx, free_idx;
	logic [IW-1:0] res_idx;
	logic res_fail;
	logic [IW+SLOT_W-1:0] res_wide;

	assign cfg_ready = 1'b1;
	assign cmd_ready = !cmd_valid_s1;
	assign advance = cmd_valid_s1 && (!res_valid || res_ready);

	// Hold the player slot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			player_q <= cfg_data;
		end
	end

	// Register the command beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_valid && cmd_ready) begin
			cmd_valid_s1 <= 1'b1;
		end else if (advance) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) cmd_s1 <= cmd;
	end

	// Broadcast to the row
	assign ins_ok = !chain[SLOTS].exact_seen && chain[SLOTS].free_seen;
	assign op = '{fire: advance, ins_ok: ins_ok, player: player_q, req: cmd_s1};
	assign chain[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		kst_cell #(.IDX(i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.op(op),
			.chain_in(chain[i]),
			.chain_out(chain[i+1]),
			.hit(hits[i])
		);
		assign key_vec[i] = hits[i].key_first;
		assign pos_vec[i] = hits[i].pos_first;
		assign free_vec[i] = hits[i].free_first;
	end

	// Encode the one-hot first hits into slot numbers
	always_comb begin
		key_idx = '0;
		pos_idx = '0;
		free_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (key_vec[i]) key_idx |= IW'(i);
			if (pos_vec[i]) pos_idx |= IW'(i);
			if (free_vec[i]) free_idx |= IW'(i);
		end
	end

	// Pick the result for the command
	always_comb begin
		res_idx = NONE_IDX;
		res_fail = 1'b1;
		case (cmd_s1.command)
			CMD_INSERT: begin
				res_idx = ins_ok ? free_idx : NONE_IDX;
				res_fail = !ins_ok;
			end
			CMD_LOOKUP_KEY, CMD_REMOVE_KEY: begin
				res_idx = chain[SLOTS].key_seen ? key_idx : NONE_IDX;
				res_fail = !chain[SLOTS].key_seen;
			end
			CMD_LOOKUP_POS: begin
				res_idx = chain[SLOTS].pos_seen ? pos_idx : NONE_IDX;
				res_fail = !chain[SLOTS].pos_seen;
			end
			CMD_REMOVE_ALL: begin
				res_idx = NONE_IDX;
				res_fail = 1'b0;
			end
			default: begin
				res_idx = NONE_IDX;
				res_fail = 1'b1;
			end
		endcase
	end

	assign res_wide = {{SLOT_W{1'b0}}, res_idx};

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res.slot <= res_wide[SLOT_W-1:0];
			res.failed <= res_fail;
		end
	end

`ifndef SYNTH
	a_fail_none: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.failed |-> res.slot == NONE_SLOT)
		else $error("failed result carries a slot number");
	a_adv_res: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid)
		else $error("processed command produced no result");
	a_key_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_s1 |-> $onehot0(key_vec))
		else $error("more than one first key hit");
	a_free_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_s1 |-> $onehot0(free_vec))
		else $error("more than one free slot picked");
	a_ins_found: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1.command == CMD_INSERT) && ins_ok |-> $onehot(free_vec))
		else $error("insert accepted without a free slot");
`endif

endmodule

// File: test/tb_keyed_slot_table_top.sv
// Self-checking testbench for keyed_slot_table_top: directed command table, then random
// phases with player_slot rewritten between them; results are checked against a table model.
// Depends on kst_pkg and the keyed_slot_table_top RTL.
module tb_keyed_slot_table_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kst_pkg::*;

	localparam int SLOTS = 16;
	localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(SLOTS);
	localparam logic [2:0] CMD_BAD_LO = 3'd5;
	localparam logic [2:0] CMD_BAD_HI = 3'd7;
	localparam int POOL = 24;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 150;
	localparam int FILL_START = 60;
	localparam int FILL_LEN = 18;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 6;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		bit typed;
		res_t res;
	} answer_t;

	typedef struct packed {
		cmd_t c;
		answer_t ans;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_ready;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [PLAYER_W-1:0] cfg_data;

	// Table model
	bit tbl_active [SLOTS];
	logic [7:0] tbl_id [SLOTS];
	logic [7:0] tbl_map [SLOTS];
	logic [7:0] tbl_grp [SLOTS];
	logic [15:0] tbl_x [SLOTS];
	logic [15:0] tbl_y [SLOTS];
	logic [PLAYER_W-1:0] model_player;

	// Keys offered by the random part, so lookups and removals hit
	logic [7:0] pool_id [POOL];
	logic [7:0] pool_map [POOL];
	logic [7:0] pool_grp [POOL];
	logic [15:0] pool_x [POOL];
	logic [15:0] pool_y [POOL];

	res_t pending_results [$];
	answer_t directed_answers [$];
	dir_row_t directed_rows [$];
	int mismatch_count;
	int cycle_count;
	bit hold_request;
	int hold_left;
	int idle_left;
	int rx_gap;
	res_t mon_pred;
	answer_t mon_ans;
	res_t mon_want;

	keyed_slot_table_top #(
		.SLOTS(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Lowest active slot whose key matches; a wildcard id ignores the map
	function automatic int key_slot(cmd_t c);
		for (int s = 0; s < SLOTS; s++) begin
			if (tbl_active[s] && tbl_id[s] == c.local_id &&
					(c.local_id == WILD_ID ||
					(tbl_map[s] == c.map_num && tbl_grp[s] == c.map_group)))
				return s;
		end
		return SLOTS;
	endfunction

	function automatic int pos_slot(cmd_t c);
		for (int s = 0; s < SLOTS; s++) begin
			if (tbl_active[s] && tbl_x[s] == c.x && tbl_y[s] == c.y)
				return s;
		end
		return SLOTS;
	endfunction

	// Apply one command to the table model and return its result beat
	function automatic res_t predict_table(cmd_t c);
		res_t r;
		int hit;
		int free_s;
		bit dup;
		r.slot = NONE_SLOT;
		r.failed = 1'b1;
		hit = SLOTS;
		case (c.command)
			CMD_INSERT: begin
				dup = 1'b0;
				free_s = SLOTS;
				for (int s = 0; s < SLOTS; s++) begin
					if (tbl_active[s] && tbl_id[s] == c.local_id &&
							tbl_map[s] == c.map_num && tbl_grp[s] == c.map_group)
						dup = 1'b1;
					if (!tbl_active[s] && free_s == SLOTS)
						free_s = s;
				end
				if (!dup && free_s < SLOTS) begin
					tbl_active[free_s] = 1'b1;
					tbl_id[free_s] = c.local_id;
					tbl_map[free_s] = c.map_num;
					tbl_grp[free_s] = c.map_group;
					tbl_x[free_s] = c.x + POS_BIAS;
					tbl_y[free_s] = c.y + POS_BIAS;
					r.slot = SLOT_W'(free_s);
					r.failed = 1'b0;
				end
			end
			CMD_LOOKUP_KEY, CMD_REMOVE_KEY, CMD_LOOKUP_POS: begin
				hit = (c.command == CMD_LOOKUP_POS) ? pos_slot(c) : key_slot(c);
				if (hit < SLOTS) begin
					r.slot = SLOT_W'(hit);
					r.failed = 1'b0;
					if (c.command == CMD_REMOVE_KEY)
						tbl_active[hit] = 1'b0;
				end
			end
			CMD_REMOVE_ALL: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (s != model_player)
						tbl_active[s] = 1'b0;
				end
				r.failed = 1'b0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic dir_row_t mk_row(logic [2:0] op, logic [7:0] id, logic [7:0] mn,
			logic [7:0] mg, logic [15:0] px, logic [15:0] py, bit typed,
			logic [SLOT_W-1:0] slot, logic failed);
		dir_row_t d;
		d.c.command = op;
		d.c.local_id = id;
		d.c.map_num = mn;
		d.c.map_group = mg;
		d.c.x = px;
		d.c.y = py;
		d.ans.typed = typed;
		d.ans.res.slot = slot;
		d.ans.res.failed = failed;
		return d;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Random command, mostly on keys from the pool; fill forces a fresh insert
	function automatic cmd_t random_cmd(bit fill);
		cmd_t c;
		int r;
		int k;
		bit fresh;
		k = $urandom_range(0, POOL - 1);
		c.local_id = pool_id[k];
		c.map_num = pool_map[k];
		c.map_group = pool_grp[k];
		c.x = pool_x[k];
		c.y = pool_y[k];
		r = fill ? 0 : $urandom_range(0, 99);
		fresh = fill || ($urandom_range(0, 3) == 0);
		if (r < 38)
			c.command = CMD_INSERT;
		else if (r < 58)
			c.command = CMD_LOOKUP_KEY;
		else if (r < 70)
			c.command = CMD_LOOKUP_POS;
		else if (r < 90)
			c.command = CMD_REMOVE_KEY;
		else if (r < 94)
			c.command = CMD_REMOVE_ALL;
		else if (r < 97)
			c.command = 3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO));
		else begin
			c.command = 3'($urandom);
			c.local_id = 8'($urandom);
			c.map_num = 8'($urandom);
			c.map_group = 8'($urandom);
			c.x = 16'($urandom);
			c.y = 16'($urandom);
			return c;
		end
		if (fresh) begin
			c.local_id = 8'($urandom);
			c.map_num = 8'($urandom);
			c.map_group = 8'($urandom);
			c.x = 16'($urandom);
			c.y = 16'($urandom);
			if (c.command == CMD_INSERT) begin
				pool_id[k] = c.local_id;
				pool_map[k] = c.map_num;
				pool_grp[k] = c.map_group;
				pool_x[k] = c.x;
				pool_y[k] = c.y;
			end
		end
		// Aim position lookups at the stored, biased position most of the time
		if (c.command == CMD_LOOKUP_POS && $urandom_range(0, 3) != 0) begin
			c.x = pool_x[k] + POS_BIAS;
			c.y = pool_y[k] + POS_BIAS;
		end
		if ((c.command == CMD_LOOKUP_KEY || c.command == CMD_REMOVE_KEY) &&
				$urandom_range(0, 6) == 0)
			c.local_id = WILD_ID;
		return c;
	endfunction

	// Offer one command beat and hold it until accepted
	task automatic send_item(cmd_t c, answer_t ans);
		directed_answers.push_back(ans);
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	task automatic pause_sender(bit calm);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected beat has come back
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_player(logic [PLAYER_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Model state and driven inputs at time zero
	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		model_player = '0;
		mismatch_count = 0;
		hold_request = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			tbl_active[s] = 1'b0;
			tbl_id[s] = 8'hFF;
			tbl_map[s] = 8'hFF;
			tbl_grp[s] = 8'hFF;
			tbl_x[s] = '0;
			tbl_y[s] = '0;
		end
	end

	// Receiver: random stalls, calm stretches, and one long hold-off on request
	initial begin
		res_ready = 1'b0;
		hold_left = 0;
		idle_left = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				res_ready <= 1'b0;
			end else if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res_ready <= 1'b0;
			end else if (idle_left > 0) begin
				res_ready <= 1'b0;
				idle_left--;
			end else if (cycle_count % 700 < 120) begin
				res_ready <= 1'b1;
			end else begin
				rx_gap = idle_len();
				if (rx_gap > 0) begin
					idle_left = rx_gap - 1;
					res_ready <= 1'b0;
				end else begin
					res_ready <= 1'b1;
				end
			end
		end
	end

	// Track accepted beats: predict on commands, compare on results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model_player = cfg_data;
			if (cmd_valid && cmd_ready) begin
				mon_ans = directed_answers.pop_front();
				mon_pred = predict_table(cmd);
				pending_results.push_back(mon_ans.typed ? mon_ans.res : mon_pred);
			end
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result beat with none expected: slot %0d failed %0b",
						$realtime, res.slot, res.failed);
				end else begin
					mon_want = pending_results.pop_front();
					if (res.slot !== mon_want.slot || res.failed !== mon_want.failed) begin
						mismatch_count++;
						$display("%0t: expected slot %0d failed %0b, got slot %0d failed %0b",
							$realtime, mon_want.slot, mon_want.failed, res.slot, res.failed);
					end
				end
			end
		end
	end

	// Stop a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("keyed_slot_table_top test failed");
			$finish;
		end
	end

	// Stimulus
	initial begin
		logic [PLAYER_W-1:0] player_plan [PHASES];
		answer_t no_answer;
		cmd_t c;

		no_answer = '0;
		player_plan = '{4'd15, 4'd0, 4'd9, 4'd15, 4'd3, 4'd0};
		player_plan[2] = PLAYER_W'($urandom);
		player_plan[4] = PLAYER_W'($urandom);
		for (int k = 0; k < POOL; k++) begin
			pool_id[k] = (k < 3) ? WILD_ID : 8'($urandom);
			pool_map[k] = 8'($urandom);
			pool_grp[k] = 8'($urandom);
			pool_x[k] = 16'($urandom);
			pool_y[k] = 16'($urandom);
		end

		// Empty table, unknown codes, extremes, wildcard and bias cases
		directed_rows.push_back(mk_row(CMD_LOOKUP_KEY, 8'h00, 8'h00, 8'h00, 16'h0000,
			16'h0000, 1'b1, NONE_SLOT, 1'b1));
		directed_rows.push_back(mk_row(CMD_LOOKUP_KEY, WILD_ID, 8'h12, 8'h34, 16'h0000,
			16'h0000, 1'b1, NONE_SLOT, 1'b1));
		directed_rows.push_back(mk_row(CMD_LOOKUP_POS, 8'h00, 8'h00, 8'h00, 16'h0000,
			16'h0000, 1'b1, NONE_SLOT, 1'b1));
		directed_rows.push_back(mk_row(CMD_REMOVE_KEY, WILD_ID, 8'hFF, 8'hFF, 16'h0000,
			16'h0000, 1'b1, NONE_SLOT, 1'b1));
		directed_rows.push_back(mk_row(CMD_REMOVE_KEY, 8'hFE, 8'hFF, 8'hFF, 16'h0000,
			16'h0000, 1'b1, NONE_SLOT, 1'b1));
		directed_rows.push_back(mk_row(CMD_BAD_LO, 8'h00, 8'h00, 8'h00, 16'h0000,
			16'h0000, 1'b1, NONE_SLOT, 1'b1));
		directed_rows.push_back(mk_row(CMD_BAD_HI, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
			16'hFFFF, 1'b1, NONE_SLOT, 1'b1));
		directed_rows.push_back(mk_row(CMD_INSERT, 8'h00, 8'h00, 8'h00, 16'h8000,
			16'h7FFF, 1'b1, 5'd0, 1'b0));
		directed_rows.push_back(mk_row(CMD_INSERT, 8'h00, 8'h00, 8'h00, 16'h0001,
			16'h0001, 1'b1, NONE_SLOT, 1'b1));
		directed_rows.push_back(mk_row(CMD_INSERT, WILD_ID, 8'hFF, 8'hFF, 16'hFFF9,
			16'hFFFF, 1'b1, 5'd1, 1'b0));
		directed_rows.push_back(mk_row(CMD_INSERT, WILD_ID, 8'h00, 8'h00, 16'h1234,
			16'hFFF0, 1'b1, 5'd2, 1'b0));
		directed_rows.push_back(mk_row(CMD_INSERT, 8'hFE, 8'hFF, 8'hFF, 16'h7FFF,
			16'h8000, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_LOOKUP_KEY, WILD_ID, 8'h55, 8'h66, 16'h0000,
			16'h0000, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_LOOKUP_KEY, 8'hFE, 8'hFF, 8'hFF, 16'h0000,
			16'h0000, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_LOOKUP_POS, 8'h00, 8'h00, 8'h00, 16'h8007,
			16'h8006, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_LOOKUP_POS, 8'h00, 8'h00, 8'h00, 16'h0000,
			16'h0006, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_LOOKUP_POS, 8'h00, 8'h00, 8'h00, 16'h8000,
			16'h7FFF, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_REMOVE_KEY, 8'h00, 8'h00, 8'h00, 16'h0000,
			16'h0000, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_LOOKUP_KEY, 8'h00, 8'h00, 8'h00, 16'h0000,
			16'h0000, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_INSERT, 8'h01, 8'h02, 8'h03, 16'hFFF9,
			16'h0000, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_REMOVE_KEY, WILD_ID, 8'h00, 8'h00, 16'h0000,
			16'h0000, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_REMOVE_KEY, WILD_ID, 8'h00, 8'h00, 16'h0000,
			16'h0000, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_REMOVE_ALL, 8'h00, 8'h00, 8'h00, 16'h0000,
			16'h0000, 1'b1, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_LOOKUP_KEY, 8'h01, 8'h02, 8'h03, 16'h0000,
			16'h0000, 1'b0, NONE_SLOT, 1'b0));
		directed_rows.push_back(mk_row(CMD_LOOKUP_KEY, 8'hFE, 8'hFF, 8'hFF, 16'h0000,
			16'h0000, 1'b0, NONE_SLOT, 1'b0));

		// Hold reset, then release at an edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Walk the directed table
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].c, directed_rows[i].ans);
			pause_sender(1'b0);
		end

		// Random phases, each under a new player slot
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_player(player_plan[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Keep offering beats while the receiver holds off
				if ((p == 1 || p == 4) && i == 20)
					hold_request = 1'b1;
				c = random_cmd(i >= FILL_START && i < FILL_START + FILL_LEN);
				send_item(c, no_answer);
				pause_sender(p == 2);
			end
		end

		drain();
		if (mismatch_count == 0)
			$display("keyed_slot_table_top test passed");
		else
			$display("keyed_slot_table_top test failed");
		$finish;
	end
endmodule
